// ===== rtl/ssf_pkg.sv =====
// Shared types and constants for the seven-segment scan driver with flash.
// No dependencies; imported by ssf_in_if, ssf_out_buf and the top level.
`timescale 1ns / 1ps

package ssf_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_WRITE  = 2'd1,
    OP_TICK   = 2'd2,
    OP_TOGGLE = 2'd3
  } ssf_op_t;

  typedef enum logic [1:0] {
    REG_DIGITS       = 2'd0,
    REG_FLASH_FIRST  = 2'd1,
    REG_FLASH_LAST   = 2'd2,
    REG_FLASH_PERIOD = 2'd3
  } ssf_reg_t;

  localparam int CFG_W = 16;

  localparam logic [7:0] POINT_BIT = 8'h80;
  localparam logic [3:0] DIGITS_RST = 4'd4;

  typedef struct packed {
    logic [7:0] segments;
    logic [2:0] digit_select;
  } ssf_result_t;

  // BCD to segments a..g, blank above nine
  function automatic logic [7:0] bcd_to_seg(input logic [3:0] v);
    logic [7:0] s;
    unique case (v)
      4'd0:    s = 8'h3F;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5B;
      4'd3:    s = 8'h4F;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6D;
      4'd6:    s = 8'h7D;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h6F;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/ssf_if.sv =====
// Valid/ready channel interfaces for the scan driver: command in, segment result out.
// Depends on ssf_pkg.
`timescale 1ns / 1ps

interface ssf_in_if;
  import ssf_pkg::*;
  logic       valid;
  logic       ready;
  ssf_op_t    operation;
  logic [2:0] position;
  logic [3:0] bcd_value;

  modport source (output valid, operation, position, bcd_value, input ready);
  modport sink   (input valid, operation, position, bcd_value, output ready);
endinterface

interface ssf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] segments;
  logic [2:0] digit_select;

  modport source (output valid, segments, digit_select, input ready);
  modport sink   (input valid, segments, digit_select, output ready);
endinterface

// ===== rtl/ssf_out_buf.sv =====
// Two-entry result buffer (output register plus skid stage) driving the result channel.
// Depends on ssf_pkg and ssf_out_if.
`timescale 1ns / 1ps

module ssf_out_buf (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  ssf_pkg::ssf_result_t push_data,
  output logic                can_take,
  ssf_out_if.source           out_ch
);
  import ssf_pkg::*;

  logic        out_valid;
  ssf_result_t out_data;
  logic        skid_valid;
  ssf_result_t skid_data;
  logic        pop;

  assign pop      = out_valid && out_ch.ready;
  assign can_take = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_data  <= push_data;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= push_data;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.segments     = out_data.segments;
  assign out_ch.digit_select = out_data.digit_select;

endmodule

// ===== rtl/seven_segment_scan_with_flash.sv =====
// Top level of the multiplexed seven-segment scan driver with digit flashing.
// Depends on ssf_pkg, ssf_in_if, ssf_out_if and ssf_out_buf.
//
// Usage:
//   in_ch carries commands: clear all, write a BCD digit at a position,
//   refresh tick, toggle decimal point. Only a refresh tick gives a result
//   on out_ch: the segment byte of the next scanned digit (blanked when it
//   sits in the flash range during the dark half of the flash period) and
//   that digit's index.
//   A command is taken on every cycle in_ch.ready is high: one per cycle.
//   A tick's result is registered, into the skid stage if out_ch stalls.
//   Results queue in a two-entry buffer (output register and skid stage);
//   in_ch.ready drops only while both entries hold a result.
//   Configuration: cfg_we with cfg_index and cfg_data; writes take effect at
//   once. User must write only while the block is idle (not enforced).
//   Reset (synchronous, rst high) clears the segment store, the flash
//   counter and the result buffer, loads register defaults and sets the
//   scan to the last digit in use, so the first tick shows digit 0.
`timescale 1ns / 1ps

module seven_segment_scan_with_flash #(
  parameter int MAX_DIGITS = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  ssf_in_if.sink                    in_ch,
  ssf_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  ssf_pkg::ssf_reg_t         cfg_index,
  input  logic [ssf_pkg::CFG_W-1:0] cfg_data
);
  import ssf_pkg::*;

  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int RST_N = (MAX_DIGITS < 4) ? MAX_DIGITS : 4;
  localparam logic [4:0] MAXD = 5'(MAX_DIGITS);
  localparam logic [IDX_W-1:0] ACTIVE_RST = IDX_W'(RST_N - 1);

  logic [7:0]       seg_mem [MAX_DIGITS];
  logic [IDX_W-1:0] scan_digit;
  logic [15:0]      flash_count;
  logic [3:0]       digits_in_use;
  logic [2:0]       flash_first;
  logic [2:0]       flash_last;
  logic [15:0]      flash_period;

  logic             accept;
  logic             can_take;
  logic [4:0]       n_digits;
  logic [4:0]       next_ext;
  logic [4:0]       pos_ext;
  logic [IDX_W-1:0] next_idx;
  logic [IDX_W-1:0] pos_idx;
  logic [IDX_W-1:0] rd_addr;
  logic [7:0]       rd_data;
  logic [16:0]      count_inc;
  logic [15:0]      flash_count_next;
  logic             in_range;
  logic             dark;
  ssf_result_t      result;

  assign in_ch.ready = can_take;
  assign accept      = in_ch.valid && can_take;

  // digit count clamped to 1..MAX_DIGITS
  always_comb begin
    if (digits_in_use == 4'd0) begin
      n_digits = 5'd1;
    end else if ({1'b0, digits_in_use} > MAXD) begin
      n_digits = MAXD;
    end else begin
      n_digits = {1'b0, digits_in_use};
    end
  end

  always_comb begin
    next_ext = 5'(scan_digit) + 5'd1;
    if (next_ext >= n_digits) begin
      next_ext = 5'd0;
    end
  end

  assign pos_ext  = {2'b00, in_ch.position};
  assign next_idx = next_ext[IDX_W-1:0];
  assign pos_idx  = pos_ext[IDX_W-1:0];
  assign rd_addr  = (in_ch.operation == OP_TOGGLE) ? pos_idx : next_idx;
  assign rd_data  = seg_mem[rd_addr];

  // flash counter advances as the scan wraps to digit 0; it stays below the period
  always_comb begin
    count_inc        = {1'b0, flash_count} + 17'd1;
    flash_count_next = flash_count;
    if (flash_period != 16'd0 && next_ext == 5'd0) begin
      flash_count_next = (count_inc >= {1'b0, flash_period}) ? 16'd0 : count_inc[15:0];
    end
  end

  assign in_range = (next_ext >= {2'b00, flash_first}) && (next_ext <= {2'b00, flash_last});
  assign dark     = (flash_period != 16'd0) && in_range &&
                    (flash_count_next > {1'b0, flash_period[15:1]});

  assign result.segments     = dark ? 8'h00 : rd_data;
  assign result.digit_select = next_ext[2:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_DIGITS; i++) begin
        seg_mem[i] <= 8'h00;
      end
      scan_digit    <= ACTIVE_RST;
      flash_count   <= 16'd0;
      digits_in_use <= DIGITS_RST;
      flash_first   <= 3'd0;
      flash_last    <= 3'd0;
      flash_period  <= 16'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DIGITS: begin
          digits_in_use <= cfg_data[3:0];
          if (cfg_data[3:0] == 4'd0) begin
            scan_digit <= '0;
          end else if ({1'b0, cfg_data[3:0]} > MAXD) begin
            scan_digit <= IDX_W'(MAX_DIGITS - 1);
          end else begin
            scan_digit <= IDX_W'(cfg_data[3:0] - 4'd1);
          end
        end
        REG_FLASH_FIRST: begin
          flash_first <= cfg_data[2:0];
          flash_count <= 16'd0;
        end
        REG_FLASH_LAST: begin
          flash_last  <= cfg_data[2:0];
          flash_count <= 16'd0;
        end
        REG_FLASH_PERIOD: begin
          flash_period <= cfg_data;
          flash_count  <= 16'd0;
        end
      endcase
    end else if (accept) begin
      unique case (in_ch.operation)
        OP_CLEAR: begin
          for (int i = 0; i < MAX_DIGITS; i++) begin
            seg_mem[i] <= 8'h00;
          end
        end
        OP_WRITE: begin
          if (pos_ext < n_digits) begin
            seg_mem[pos_idx] <= bcd_to_seg(in_ch.bcd_value);
          end
        end
        OP_TOGGLE: begin
          if (pos_ext < MAXD) begin
            seg_mem[pos_idx] <= rd_data ^ POINT_BIT;
          end
        end
        OP_TICK: begin
          scan_digit  <= next_idx;
          flash_count <= flash_count_next;
        end
      endcase
    end
  end

  ssf_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && in_ch.operation == OP_TICK),
    .push_data (result),
    .can_take  (can_take),
    .out_ch    (out_ch)
  );

endmodule

// ===== rtl/ssf_check.sv =====
// Port-level checks for the seven-segment scan driver, bound to the top level.
// Depends on seven_segment_scan_with_flash's port names only.
`timescale 1ns / 1ps

module ssf_check (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);

  // a pending result is never dropped
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // result buffer is empty straight after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid after reset");

  // a result only appears after a command transfer
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result without a command transfer");

  // input back-pressure only while results are waiting
  a_ready_reason: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

endmodule

bind seven_segment_scan_with_flash ssf_check u_ssf_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready)
);
